/* design/pecs_pkg.sv */
`timescale 1ns / 1ps

package pecs_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int COORD_BITS   = 16;

    localparam int CW    = COORD_BITS;     // coordinate
    localparam int DW    = CW + 1;         // coordinate difference
    localparam int PW    = 2 * DW;         // product of two differences
    localparam int SW    = PW + 1;         // side value and denominator
    localparam int AW    = 2 * CW + 1;     // line constants a and d
    localparam int NPW   = AW + DW;        // numerator partial product
    localparam int NW    = NPW + 1;        // numerator
    localparam int CNT_W = $clog2(NW + 1);
    localparam int TOT_W = 7;

    localparam logic [TOT_W-1:0] COUNT_CAP =
        TOT_W'(((2 * MAX_VERTICES) < 127) ? (2 * MAX_VERTICES) : 127);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic ITEM_VERTEX = 1'b0;
    localparam logic ITEM_END    = 1'b1;

    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } t_cfg_idx;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord vert_x;
        t_coord vert_y;
        logic   final_vertex;
    } t_vert_in;

    typedef struct packed {
        logic             item_kind;
        t_coord           out_x;
        t_coord           out_y;
        logic [TOT_W-1:0] vertex_total;
    } t_clip_out;

    typedef struct packed {
        logic   is_end;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_task;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_clip_edge;

endpackage

/* design/pecs_front.sv */
`timescale 1ns / 1ps

module pecs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pecs_pkg::t_vert_in i_in_data,
    input  logic               i_q_full,
    output logic               o_push,
    output pecs_pkg::t_task    o_task
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_EDGE  = 4'b0010,
        F_CLOSE = 4'b0100,
        F_END   = 4'b1000
    } t_fstate;

    t_fstate         r_state, n_state;
    pecs_pkg::t_coord r_first_x, r_first_y, r_prev_x, r_prev_y;
    pecs_pkg::t_coord r_sx, r_sy, r_cx, r_cy;
    logic            r_have_prev, r_last;
    logic            accept;

    assign accept     = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_task  = '0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (r_have_prev) begin
                        n_state = F_EDGE;
                    end else if (i_in_data.final_vertex) begin
                        n_state = F_CLOSE;
                    end
                end
            end
            F_EDGE: begin
                o_task = '{is_end: 1'b0, sx: r_sx, sy: r_sy, ex: r_cx, ey: r_cy};
                o_push = !i_q_full;
                if (!i_q_full) begin
                    n_state = r_last ? F_CLOSE : F_IDLE;
                end
            end
            F_CLOSE: begin
                o_task = '{is_end: 1'b0, sx: r_cx, sy: r_cy, ex: r_first_x, ey: r_first_y};
                o_push = !i_q_full;
                if (!i_q_full) begin
                    n_state = F_END;
                end
            end
            F_END: begin
                o_task.is_end = 1'b1;
                o_push        = !i_q_full;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_have_prev <= 1'b0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                // edge start is the previous vertex, taken before it is replaced
                r_sx        <= r_prev_x;
                r_sy        <= r_prev_y;
                r_cx        <= i_in_data.vert_x;
                r_cy        <= i_in_data.vert_y;
                r_last      <= i_in_data.final_vertex;
                r_prev_x    <= i_in_data.vert_x;
                r_prev_y    <= i_in_data.vert_y;
                r_have_prev <= !i_in_data.final_vertex;
                if (!r_have_prev) begin
                    r_first_x <= i_in_data.vert_x;
                    r_first_y <= i_in_data.vert_y;
                end
            end
        end
    end

endmodule

/* design/pecs_queue.sv */
`timescale 1ns / 1ps

module pecs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pecs_pkg::t_task i_data,
    input  logic            i_pop,
    output pecs_pkg::t_task o_head,
    output logic            o_full,
    output logic            o_empty
);

    pecs_pkg::t_task               r_mem [pecs_pkg::QUEUE_DEPTH];
    logic [pecs_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [pecs_pkg::QPTR_W:0]     r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == (pecs_pkg::QPTR_W+1)'(pecs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* design/pecs_div.sv */
`timescale 1ns / 1ps

module pecs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [pecs_pkg::NW-1:0] i_num_x,
    input  logic signed [pecs_pkg::NW-1:0] i_num_y,
    input  logic signed [pecs_pkg::SW-1:0] i_den,
    output logic                         o_busy,
    output pecs_pkg::t_coord             o_qx,
    output pecs_pkg::t_coord             o_qy
);

    localparam int NW = pecs_pkg::NW;
    localparam int SW = pecs_pkg::SW;
    localparam int CW = pecs_pkg::CW;

    logic                        r_busy;
    logic [pecs_pkg::CNT_W-1:0]  r_cnt;
    logic [NW-1:0]               r_nx, r_ny;
    logic [SW-1:0]               r_ud, r_rx, r_ry;
    logic [CW-1:0]               r_qx, r_qy;
    logic                        r_negx, r_negy, r_dz;
    logic [SW:0]                 trial_x, trial_y;
    logic                        ge_x, ge_y;
    logic [SW-1:0]               n_rx, n_ry;

    // restoring division on magnitudes, one quotient bit per lane per cycle;
    // only the low coordinate bits of the quotient are kept
    assign trial_x = {r_rx, r_nx[NW-1]};
    assign trial_y = {r_ry, r_ny[NW-1]};
    assign ge_x    = (trial_x >= {1'b0, r_ud});
    assign ge_y    = (trial_y >= {1'b0, r_ud});
    assign n_rx    = ge_x ? SW'(trial_x - {1'b0, r_ud}) : SW'(trial_x);
    assign n_ry    = ge_y ? SW'(trial_y - {1'b0, r_ud}) : SW'(trial_y);

    assign o_busy = r_busy;
    assign o_qx   = r_dz ? '0 : (r_negx ? -r_qx : r_qx);
    assign o_qy   = r_dz ? '0 : (r_negy ? -r_qy : r_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pecs_pkg::CNT_W'(NW);
            r_nx   <= i_num_x[NW-1] ? NW'(-i_num_x) : NW'(i_num_x);
            r_ny   <= i_num_y[NW-1] ? NW'(-i_num_y) : NW'(i_num_y);
            r_ud   <= i_den[SW-1] ? SW'(-i_den) : SW'(i_den);
            r_negx <= i_num_x[NW-1] ^ i_den[SW-1];
            r_negy <= i_num_y[NW-1] ^ i_den[SW-1];
            r_dz   <= (i_den == '0);
            r_rx   <= '0;
            r_ry   <= '0;
            r_qx   <= '0;
            r_qy   <= '0;
        end else if (r_busy) begin
            r_nx  <= {r_nx[NW-2:0], 1'b0};
            r_ny  <= {r_ny[NW-2:0], 1'b0};
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_qx  <= {r_qx[CW-2:0], ge_x};
            r_qy  <= {r_qy[CW-2:0], ge_y};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == pecs_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

/* design/pecs_back.sv */
`timescale 1ns / 1ps

module pecs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pecs_pkg::t_clip_edge i_edge,
    input  logic                 i_empty,
    input  pecs_pkg::t_task      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pecs_pkg::t_clip_out  o_out_data
);

    localparam int DW  = pecs_pkg::DW;
    localparam int PW  = pecs_pkg::PW;
    localparam int SW  = pecs_pkg::SW;
    localparam int AW  = pecs_pkg::AW;
    localparam int NPW = pecs_pkg::NPW;
    localparam int NW  = pecs_pkg::NW;

    typedef enum logic [10:0] {
        B_IDLE   = 11'b00000000001,
        B_MARK   = 11'b00000000010,
        B_SIDE   = 11'b00000000100,
        B_CLASS  = 11'b00000001000,
        B_PROD1  = 11'b00000010000,
        B_PROD2  = 11'b00000100000,
        B_PROD3  = 11'b00001000000,
        B_NUM    = 11'b00010000000,
        B_DIV    = 11'b00100000000,
        B_EMIT_X = 11'b01000000000,
        B_EMIT_E = 11'b10000000000
    } t_bstate;

    t_bstate                      r_state, n_state;
    pecs_pkg::t_task              r_task;
    logic signed [PW-1:0]         r_m [6];
    logic signed [AW-1:0]         r_a, r_d;
    logic signed [SW-1:0]         r_den;
    logic signed [NPW-1:0]        r_n [4];
    logic                         r_e_in;
    logic [pecs_pkg::TOT_W-1:0]   r_count;
    logic                         r_out_valid;
    pecs_pkg::t_clip_out          r_out, n_out;
    logic                         load, div_start, div_busy, slot_free;
    logic                         s_in, e_in;
    pecs_pkg::t_coord             qx, qy;
    logic signed [SW-1:0]         side_s, side_e;
    logic signed [NW-1:0]         num_x, num_y;
    logic signed [DW-1:0]         dx21, dy21, dsx1, dsy1, dex1, dey1;
    logic signed [DW-1:0]         dx12, dy12, dsex, dsey;

    assign dx21 = DW'(i_edge.end_x) - DW'(i_edge.start_x);
    assign dy21 = DW'(i_edge.end_y) - DW'(i_edge.start_y);
    assign dx12 = DW'(i_edge.start_x) - DW'(i_edge.end_x);
    assign dy12 = DW'(i_edge.start_y) - DW'(i_edge.end_y);
    assign dsx1 = DW'(r_task.sx) - DW'(i_edge.start_x);
    assign dsy1 = DW'(r_task.sy) - DW'(i_edge.start_y);
    assign dex1 = DW'(r_task.ex) - DW'(i_edge.start_x);
    assign dey1 = DW'(r_task.ey) - DW'(i_edge.start_y);
    assign dsex = DW'(r_task.sx) - DW'(r_task.ex);
    assign dsey = DW'(r_task.sy) - DW'(r_task.ey);

    // inside means strictly negative cross product
    assign side_s = SW'(r_m[0]) - SW'(r_m[1]);
    assign side_e = SW'(r_m[2]) - SW'(r_m[3]);
    assign s_in   = side_s[SW-1];
    assign e_in   = side_e[SW-1];

    assign num_x = NW'(r_n[0]) - NW'(r_n[1]);
    assign num_y = NW'(r_n[2]) - NW'(r_n[3]);

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pecs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_x (num_x),
        .i_num_y (num_y),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load      = 1'b0;
        div_start = 1'b0;
        n_out     = '0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_head.is_end ? B_MARK : B_SIDE;
                end
            end
            B_MARK: begin
                n_out.item_kind    = pecs_pkg::ITEM_END;
                n_out.vertex_total = r_count;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_SIDE: n_state = B_CLASS;
            B_CLASS: begin
                if (s_in && e_in) begin
                    n_state = B_EMIT_E;
                end else if (s_in || e_in) begin
                    n_state = B_PROD1;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_PROD1: n_state = B_PROD2;
            B_PROD2: n_state = B_PROD3;
            B_PROD3: n_state = B_NUM;
            B_NUM: begin
                div_start = 1'b1;
                n_state   = B_DIV;
            end
            B_DIV: begin
                if (!div_busy) begin
                    n_state = B_EMIT_X;
                end
            end
            B_EMIT_X: begin
                n_out.item_kind = pecs_pkg::ITEM_VERTEX;
                n_out.out_x     = qx;
                n_out.out_y     = qy;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = r_e_in ? B_EMIT_E : B_IDLE;
                end
            end
            B_EMIT_E: begin
                n_out.item_kind = pecs_pkg::ITEM_VERTEX;
                n_out.out_x     = r_task.ex;
                n_out.out_y     = r_task.ey;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_task <= i_head;
        end
        if (r_state == B_SIDE) begin
            r_m[0] <= dx21 * dsy1;
            r_m[1] <= dy21 * dsx1;
            r_m[2] <= dx21 * dey1;
            r_m[3] <= dy21 * dex1;
        end
        if (r_state == B_CLASS) begin
            r_e_in <= e_in;
        end
        if (r_state == B_PROD1) begin
            r_m[0] <= i_edge.start_x * i_edge.end_y;
            r_m[1] <= i_edge.start_y * i_edge.end_x;
            r_m[2] <= r_task.sx * r_task.ey;
            r_m[3] <= r_task.sy * r_task.ex;
            r_m[4] <= dx12 * dsey;
            r_m[5] <= dy12 * dsex;
        end
        if (r_state == B_PROD2) begin
            r_a   <= AW'(r_m[0]) - AW'(r_m[1]);
            r_d   <= AW'(r_m[2]) - AW'(r_m[3]);
            r_den <= SW'(r_m[4]) - SW'(r_m[5]);
        end
        if (r_state == B_PROD3) begin
            r_n[0] <= r_a * dsex;
            r_n[1] <= dx12 * r_d;
            r_n[2] <= r_a * dsey;
            r_n[3] <= dy12 * r_d;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
                if (n_out.item_kind == pecs_pkg::ITEM_END) begin
                    r_count <= '0;
                end else if (r_count < pecs_pkg::COUNT_CAP) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* design/polygon_edge_clip_stage.sv */
`timescale 1ns / 1ps
// a vertex needing no intersection passes the front, the queue and the back states side, class and emit
// an intersection also passes the product and numerator states and the 51-step restoring divider
// input: the front stalls while it pushes an edge or the end marker; a 4-entry queue buffers edges
// back end: works on one queued task at a time and holds each output while i_out_stall is high
// reset: synchronous active-low, clears control state, edge registers and polygon state

module polygon_edge_clip_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pecs_pkg::t_vert_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pecs_pkg::t_clip_out  o_out_data,
    input  logic                 i_cfg_we,
    input  pecs_pkg::t_cfg_idx   i_cfg_idx,
    input  pecs_pkg::t_coord     i_cfg_data
);

    pecs_pkg::t_clip_edge r_edge;
    pecs_pkg::t_task      w_task, w_head;
    logic                 w_push, w_pop, w_full, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pecs_pkg::CFG_START_X: r_edge.start_x <= i_cfg_data;
                pecs_pkg::CFG_START_Y: r_edge.start_y <= i_cfg_data;
                pecs_pkg::CFG_END_X:   r_edge.end_x   <= i_cfg_data;
                pecs_pkg::CFG_END_Y:   r_edge.end_y   <= i_cfg_data;
                default: r_edge <= r_edge;
            endcase
        end
    end

    pecs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_task     (w_task)
    );

    pecs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_task),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pecs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge      (r_edge),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("edge queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("edge queue read while empty");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.item_kind == pecs_pkg::ITEM_END)
        |-> (o_out_data.out_x == '0 && o_out_data.out_y == '0))
        else $error("end marker carries coordinates");

    a_vertex_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.item_kind == pecs_pkg::ITEM_VERTEX)
        |-> (o_out_data.vertex_total == '0))
        else $error("vertex transaction carries a count");

endmodule
